/* hw/rtl/logic_formula_tokenizer_unit_assert.svh */
// Assertion macros used by the tokenizer RTL.
`ifndef LOGIC_FORMULA_TOKENIZER_UNIT_ASSERT_SVH
`define LOGIC_FORMULA_TOKENIZER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define LFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define LFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lft_pkg.sv */
// Package with token kinds, match modes, character constants and the class record.
package lft_pkg;

	localparam int SET_WIDTH = 52;
	localparam int SET_IDX_WIDTH = 6;

	typedef enum logic [3:0] {
		K_END     = 4'd0,
		K_INVALID = 4'd1,
		K_LPAREN  = 4'd2,
		K_RPAREN  = 4'd3,
		K_LETTER  = 4'd4,
		K_AND     = 4'd5,
		K_OR      = 4'd6,
		K_NOT     = 4'd7,
		K_ARROW   = 4'd8,
		K_BICOND  = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_LT      = 2'd1,
		MODE_LT_DASH = 2'd2,
		MODE_DASH    = 2'd3
	} mode_t;

	localparam logic [7:0] CH_OR      = 8'h76; // 'v'
	localparam logic [7:0] CH_AND     = 8'h26; // '&'
	localparam logic [7:0] CH_NOT     = 8'h7E; // '~'
	localparam logic [7:0] CH_LT      = 8'h3C; // '<'
	localparam logic [7:0] CH_DASH    = 8'h2D; // '-'
	localparam logic [7:0] CH_GT      = 8'h3E; // '>'
	localparam logic [7:0] CH_LPAREN  = 8'h28; // '('
	localparam logic [7:0] CH_RPAREN  = 8'h29; // ')'
	localparam logic [7:0] CH_NL      = 8'h0A; // '\n'
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] LOWER_SET_OFS = 8'd71; // 'a' - 26

	typedef struct packed {
		logic                     ws;
		logic                     nl;
		logic                     lt;
		logic                     dash;
		logic                     gt;
		logic                     open;
		logic                     close;
		logic                     is_letter;
		logic [SET_IDX_WIDTH-1:0] set_idx;
		kind_t                    kind;
	} class_t;

endpackage

/* hw/rtl/lft_class.sv */
// Character classifier: sorts one byte into whitespace, arrow parts and token kinds.
module lft_class
	import lft_pkg::*;
(
	input  logic [7:0] char_code,
	output class_t     cls
);

	logic upper;
	logic lower;

	assign upper = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
	assign lower = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z);

	always_comb begin
		cls.ws        = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
		cls.nl        = (char_code == CH_NL);
		cls.lt        = (char_code == CH_LT);
		cls.dash      = (char_code == CH_DASH);
		cls.gt        = (char_code == CH_GT);
		cls.open      = (char_code == CH_LPAREN);
		cls.close     = (char_code == CH_RPAREN);
		cls.is_letter = (upper || lower) && (char_code != CH_OR);
		if (upper) begin
			cls.set_idx = SET_IDX_WIDTH'(char_code - CH_UPPER_A);
		end else begin
			cls.set_idx = SET_IDX_WIDTH'(char_code - LOWER_SET_OFS);
		end
		// 'v' is OR, so it is tested before the letter ranges
		if (cls.open) begin
			cls.kind = K_LPAREN;
		end else if (cls.close) begin
			cls.kind = K_RPAREN;
		end else if (char_code == CH_OR) begin
			cls.kind = K_OR;
		end else if (cls.is_letter) begin
			cls.kind = K_LETTER;
		end else if (char_code == CH_AND) begin
			cls.kind = K_AND;
		end else if (char_code == CH_NOT) begin
			cls.kind = K_NOT;
		end else begin
			cls.kind = K_INVALID;
		end
	end

endmodule

/* hw/rtl/logic_formula_tokenizer_unit.sv */
// Path: a character word is registered on acceptance; it moves into the token buffer
//   once the buffer is free, and its first token word is then on the output.
// Throughput: one character word per cycle while each yields at most one token and
//   the sink does not stall; k tokens (up to 3) from one character hold off the next one.
// Reset: arst_n clears the match mode, all counters, the letter set and both valid flags.
// The last character word emits END and returns the scanner state to its reset values.
`include "logic_formula_tokenizer_unit_assert.svh"

module logic_formula_tokenizer_unit
	import lft_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// character input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          last_char,
	// token output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    kind,
	output logic [7:0]                    letter_code,
	output logic [COUNT_WIDTH-1:0]        start_position,
	output logic [COUNT_WIDTH-1:0]        line_number,
	output logic signed [COUNT_WIDTH-1:0] paren_depth,
	output logic [SET_WIDTH-1:0]          letter_set,
	output logic                          last_token
);

	localparam int SLOTS = 3;
	localparam logic signed [COUNT_WIDTH-1:0] DEP_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] DEP_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// ---------------------------------------------------------------------------------
	// Input register: one character word waits here until the token buffer can take
	// everything it produces.
	// ---------------------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       adv;
	logic       load_s1;
	logic       buf_free;
	logic       out_take;

	// ---------------------------------------------------------------------------------
	// Scanner state
	// ---------------------------------------------------------------------------------
	mode_t                          mode_q;
	logic [COUNT_WIDTH-1:0]         off_q;
	logic [COUNT_WIDTH-1:0]         tstart_q;
	logic [COUNT_WIDTH-1:0]         line_q;
	logic signed [COUNT_WIDTH-1:0]  depth_q;
	logic [SET_WIDTH-1:0]           set_q;

	// ---------------------------------------------------------------------------------
	// Token buffer: up to three token words from one character, drained one per cycle unless
	// out_stall is high. cnt_q counts words still to send, rd_q points at the next one.
	// ---------------------------------------------------------------------------------
	kind_t                          rk_q     [0:SLOTS-1];
	logic [7:0]                     rlet_q   [0:SLOTS-1];
	logic [COUNT_WIDTH-1:0]         rpos_q   [0:SLOTS-1];
	logic [COUNT_WIDTH-1:0]         rline_q  [0:SLOTS-1];
	logic signed [COUNT_WIDTH-1:0]  rdep_q   [0:SLOTS-1];
	logic [SET_WIDTH-1:0]           rset_q   [0:SLOTS-1];
	logic                           rlast_q  [0:SLOTS-1];
	logic [1:0]                     cnt_q;
	logic [1:0]                     rd_q;

	// next-state and new tokens from the character in the input register
	class_t                         cls;
	mode_t                          mode_c;
	logic [COUNT_WIDTH-1:0]         off_c;
	logic [COUNT_WIDTH-1:0]         tstart_c;
	logic [COUNT_WIDTH-1:0]         line_c;
	logic signed [COUNT_WIDTH-1:0]  depth_c;
	logic [SET_WIDTH-1:0]           set_c;
	logic                           relex_c;
	logic [1:0]                     n_c;
	kind_t                          nk_c     [0:SLOTS-1];
	logic [7:0]                     nlet_c   [0:SLOTS-1];
	logic [COUNT_WIDTH-1:0]         npos_c   [0:SLOTS-1];
	logic [COUNT_WIDTH-1:0]         nline_c  [0:SLOTS-1];
	logic signed [COUNT_WIDTH-1:0]  ndep_c   [0:SLOTS-1];
	logic [SET_WIDTH-1:0]           nset_c   [0:SLOTS-1];
	logic                           nlast_c  [0:SLOTS-1];

	lft_class u_class (
		.char_code (char_s1),
		.cls       (cls)
	);

	// Handshake: the buffer is free when it is empty or its final word leaves now.
	assign out_valid = (cnt_q != 2'd0);
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_take);
	assign adv       = valid_s1 && buf_free;
	assign load_s1   = !valid_s1 || adv;
	assign in_stall  = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// ---------------------------------------------------------------------------------
	// Scanner step. Each token snapshots line, depth and letter set at its emit point,
	// so the order of updates below follows the token order exactly.
	// ---------------------------------------------------------------------------------
	always_comb begin
		mode_c   = mode_q;
		off_c    = off_q;
		tstart_c = tstart_q;
		line_c   = line_q;
		depth_c  = depth_q;
		set_c    = set_q;
		relex_c  = 1'b1;
		n_c      = 2'd0;
		for (int i = 0; i < SLOTS; i++) begin
			nk_c[i]    = K_END;
			nlet_c[i]  = 8'd0;
			npos_c[i]  = '0;
			nline_c[i] = '0;
			ndep_c[i]  = '0;
			nset_c[i]  = '0;
			nlast_c[i] = 1'b0;
		end

		// continue an open arrow
		if (mode_c != MODE_IDLE) begin
			relex_c = 1'b0;
			if (cls.ws) begin
				if (cls.nl) begin
					line_c = sat_inc(line_c);
				end
			end else if ((mode_c == MODE_LT) && cls.dash) begin
				mode_c = MODE_LT_DASH;
			end else if ((mode_c == MODE_LT_DASH || mode_c == MODE_DASH) && cls.gt) begin
				nk_c[n_c]    = (mode_c == MODE_LT_DASH) ? K_BICOND : K_ARROW;
				npos_c[n_c]  = tstart_c;
				nline_c[n_c] = line_c;
				ndep_c[n_c]  = depth_c;
				nset_c[n_c]  = set_c;
				n_c          = n_c + 2'd1;
				mode_c       = MODE_IDLE;
			end else begin
				// broken arrow: flag it, then lex the failing character afresh
				nk_c[n_c]    = K_INVALID;
				npos_c[n_c]  = tstart_c;
				nline_c[n_c] = line_c;
				ndep_c[n_c]  = depth_c;
				nset_c[n_c]  = set_c;
				n_c          = n_c + 2'd1;
				mode_c       = MODE_IDLE;
				relex_c      = 1'b1;
			end
		end

		// plain lexing from idle
		if (relex_c) begin
			if (cls.ws) begin
				if (cls.nl) begin
					line_c = sat_inc(line_c);
				end
			end else if (cls.lt) begin
				mode_c   = MODE_LT;
				tstart_c = off_c;
			end else if (cls.dash) begin
				mode_c   = MODE_DASH;
				tstart_c = off_c;
			end else begin
				if (cls.open && (depth_c != DEP_MAX)) begin
					depth_c = depth_c + COUNT_WIDTH'(1);
				end
				if (cls.close && (depth_c != DEP_MIN)) begin
					depth_c = depth_c - COUNT_WIDTH'(1);
				end
				if (cls.is_letter) begin
					set_c = set_c | (SET_WIDTH'(1) << cls.set_idx);
				end
				nk_c[n_c]    = cls.kind;
				nlet_c[n_c]  = cls.is_letter ? char_s1 : 8'd0;
				npos_c[n_c]  = off_c;
				nline_c[n_c] = line_c;
				ndep_c[n_c]  = depth_c;
				nset_c[n_c]  = set_c;
				n_c          = n_c + 2'd1;
			end
		end

		off_c = sat_inc(off_c);

		// close the content: flush a dangling arrow, emit END, drop all state
		if (last_s1) begin
			if (mode_c != MODE_IDLE) begin
				nk_c[n_c]    = K_INVALID;
				npos_c[n_c]  = tstart_c;
				nline_c[n_c] = line_c;
				ndep_c[n_c]  = depth_c;
				nset_c[n_c]  = set_c;
				n_c          = n_c + 2'd1;
			end
			nk_c[n_c]    = K_END;
			npos_c[n_c]  = off_c;
			nline_c[n_c] = line_c;
			ndep_c[n_c]  = depth_c;
			nset_c[n_c]  = set_c;
			nlast_c[n_c] = 1'b1;
			n_c          = n_c + 2'd1;
			mode_c   = MODE_IDLE;
			off_c    = '0;
			tstart_c = '0;
			line_c   = '0;
			depth_c  = '0;
			set_c    = '0;
		end
	end

	// advance scanner state only when the character word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			off_q    <= '0;
			tstart_q <= '0;
			line_q   <= '0;
			depth_q  <= '0;
			set_q    <= '0;
		end else if (adv) begin
			mode_q   <= mode_c;
			off_q    <= off_c;
			tstart_q <= tstart_c;
			line_q   <= line_c;
			depth_q  <= depth_c;
			set_q    <= set_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 2'd0;
		end else if (adv) begin
			cnt_q <= n_c;
			rd_q  <= 2'd0;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SLOTS; i++) begin
				rk_q[i]    <= nk_c[i];
				rlet_q[i]  <= nlet_c[i];
				rpos_q[i]  <= npos_c[i];
				rline_q[i] <= nline_c[i];
				rdep_q[i]  <= ndep_c[i];
				rset_q[i]  <= nset_c[i];
				rlast_q[i] <= nlast_c[i];
			end
		end
	end

	// hold the current slot on the output until it is taken
	assign kind           = rk_q[rd_q];
	assign letter_code    = rlet_q[rd_q];
	assign start_position = rpos_q[rd_q];
	assign line_number    = rline_q[rd_q];
	assign paren_depth    = rdep_q[rd_q];
	assign letter_set     = rset_q[rd_q];
	assign last_token     = rlast_q[rd_q];

	// ---------------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------------
	`LFT_ASSERT_NOW(a_slot_bound, cnt_q != 2'd0, ({1'b0, rd_q} + {1'b0, cnt_q}) <= 3'd3, "token buffer read past its fill")
	`LFT_ASSERT_NOW(a_end_flag, out_valid && (rk_q[rd_q] == K_END), rlast_q[rd_q], "END word without last_token")
	`LFT_ASSERT_NEXT(a_end_clears, adv && last_s1, (mode_q == MODE_IDLE) && (off_q == '0) && (set_q == '0), "state not cleared after last character")
	`LFT_ASSERT_NEXT(a_hold_s1, valid_s1 && !adv, valid_s1 && $stable(char_s1) && $stable(last_s1), "held character word changed")

endmodule

/* tb/token_checker.sv */
// Checker that follows both tokenizer channels, predicts every token word and scores it.
module token_checker
	import lft_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          last_char,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [3:0]                    kind,
	input  logic [7:0]                    letter_code,
	input  logic [COUNT_WIDTH-1:0]        start_position,
	input  logic [COUNT_WIDTH-1:0]        line_number,
	input  logic signed [COUNT_WIDTH-1:0] paren_depth,
	input  logic [SET_WIDTH-1:0]          letter_set,
	input  logic                          last_token,
	output int                            mismatches,
	output int                            tokens_outstanding,
	output int                            tokens_checked
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
	localparam logic signed [COUNT_WIDTH-1:0] DEPTH_TOP = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] DEPTH_BOTTOM = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	typedef struct {
		kind_t                         tok_kind;
		logic [7:0]                    letter;
		logic [COUNT_WIDTH-1:0]        pos;
		logic [COUNT_WIDTH-1:0]        line;
		logic signed [COUNT_WIDTH-1:0] depth;
		logic [SET_WIDTH-1:0]          seen;
		logic                          closing;
	} token_t;

	// scanner state as the block should hold it
	mode_t                         scan_mode;
	logic [COUNT_WIDTH-1:0]        char_pos;
	logic [COUNT_WIDTH-1:0]        arrow_start;
	logic [COUNT_WIDTH-1:0]        newline_total;
	logic signed [COUNT_WIDTH-1:0] nesting;
	logic [SET_WIDTH-1:0]          letters_seen;

	token_t upcoming_tokens[$];
	token_t head_token;
	int     fail_total;
	int     checked_total;

	task automatic clear_scan();
		scan_mode     = MODE_IDLE;
		char_pos      = '0;
		arrow_start   = '0;
		newline_total = '0;
		nesting       = '0;
		letters_seen  = '0;
	endtask

	task automatic emit_token(input kind_t k, input logic [7:0] letter,
			input logic [COUNT_WIDTH-1:0] pos, input logic closing);
		token_t t;
		t.tok_kind = k;
		t.letter   = letter;
		t.pos      = pos;
		t.line     = newline_total;
		t.depth    = nesting;
		t.seen     = letters_seen;
		t.closing  = closing;
		upcoming_tokens.push_back(t);
	endtask

	task automatic count_newline();
		if (newline_total != COUNT_TOP)
			newline_total++;
	endtask

	// lex a character with no arrow in progress
	task automatic lex_fresh(input logic [7:0] c);
		logic [5:0] bit_pos;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			if (c == CH_NL)
				count_newline();
		end else if (c == CH_LPAREN) begin
			if (nesting != DEPTH_TOP)
				nesting++;
			emit_token(K_LPAREN, 8'd0, char_pos, 1'b0);
		end else if (c == CH_RPAREN) begin
			if (nesting != DEPTH_BOTTOM)
				nesting--;
			emit_token(K_RPAREN, 8'd0, char_pos, 1'b0);
		end else if (c == CH_OR) begin
			emit_token(K_OR, 8'd0, char_pos, 1'b0);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			bit_pos = 6'(c - CH_UPPER_A);
			letters_seen[bit_pos] = 1'b1;
			emit_token(K_LETTER, c, char_pos, 1'b0);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			bit_pos = 6'(c - LOWER_SET_OFS);
			letters_seen[bit_pos] = 1'b1;
			emit_token(K_LETTER, c, char_pos, 1'b0);
		end else if (c == CH_AND) begin
			emit_token(K_AND, 8'd0, char_pos, 1'b0);
		end else if (c == CH_NOT) begin
			emit_token(K_NOT, 8'd0, char_pos, 1'b0);
		end else if (c == CH_LT) begin
			scan_mode   = MODE_LT;
			arrow_start = char_pos;
		end else if (c == CH_DASH) begin
			scan_mode   = MODE_DASH;
			arrow_start = char_pos;
		end else begin
			emit_token(K_INVALID, 8'd0, char_pos, 1'b0);
		end
	endtask

	// work out the tokens one accepted character word causes
	task automatic scan_char(input logic [7:0] c, input logic is_last);
		logic blank;
		logic consumed;
		blank    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		consumed = 1'b0;
		if (scan_mode != MODE_IDLE) begin
			consumed = 1'b1;
			if (blank) begin
				if (c == CH_NL)
					count_newline();
			end else if (scan_mode == MODE_LT && c == CH_DASH) begin
				scan_mode = MODE_LT_DASH;
			end else if (scan_mode != MODE_LT && c == CH_GT) begin
				emit_token(scan_mode == MODE_LT_DASH ? K_BICOND : K_ARROW, 8'd0,
					arrow_start, 1'b0);
				scan_mode = MODE_IDLE;
			end else begin
				// broken arrow: report it, then lex the character again
				emit_token(K_INVALID, 8'd0, arrow_start, 1'b0);
				scan_mode = MODE_IDLE;
				consumed  = 1'b0;
			end
		end
		if (!consumed)
			lex_fresh(c);
		if (char_pos != COUNT_TOP)
			char_pos++;
		if (is_last) begin
			if (scan_mode != MODE_IDLE)
				emit_token(K_INVALID, 8'd0, arrow_start, 1'b0);
			emit_token(K_END, 8'd0, char_pos, 1'b1);
			clear_scan();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_scan();
			upcoming_tokens.delete();
			fail_total    = 0;
			checked_total = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (upcoming_tokens.size() == 0) begin
					$error("token word with none expected: kind %0d at %0d", kind,
						start_position);
					fail_total++;
				end else begin
					head_token = upcoming_tokens.pop_front();
					check_field("kind", 64'(head_token.tok_kind), 64'(kind));
					check_field("letter_code", 64'(head_token.letter), 64'(letter_code));
					check_field("start_position", 64'(head_token.pos), 64'(start_position));
					check_field("line_number", 64'(head_token.line), 64'(line_number));
					check_field("paren_depth", 64'(unsigned'(head_token.depth)),
						64'(unsigned'(paren_depth)));
					check_field("letter_set", 64'(head_token.seen), 64'(letter_set));
					check_field("last_token", 64'(head_token.closing), 64'(last_token));
					checked_total++;
				end
			end
			if (in_valid && !in_stall)
				scan_char(char_code, last_char);
		end
		mismatches         <= fail_total;
		tokens_outstanding <= upcoming_tokens.size();
		tokens_checked     <= checked_total;
	end

endmodule

/* tb/testbench.sv */
// Top of the tokenizer bench: clock, reset, character stimulus, token sink and verdict.
module testbench;
	import lft_pkg::*;

	localparam int COUNT_W = 16;
	// cycles with no word moving on either channel before the run is called hung
	localparam int HANG_LIMIT = 4000;
	// random words offered in each idle/stall phase
	localparam int PHASE_WORDS = 32;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [7:0]                char_code;
	logic                      last_char;
	logic                      out_valid;
	logic                      out_stall;
	logic [3:0]                kind;
	logic [7:0]                letter_code;
	logic [COUNT_W-1:0]        start_position;
	logic [COUNT_W-1:0]        line_number;
	logic signed [COUNT_W-1:0] paren_depth;
	logic [SET_WIDTH-1:0]      letter_set;
	logic                      last_token;

	int mismatches;
	int tokens_outstanding;
	int tokens_checked;

	// idle knobs, percent of cycles; the sink's hold-off is a one-shot request
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int chars_sent;
	int contents_closed;
	int quiet_cycles;

	logic_formula_tokenizer_unit #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.last_char      (last_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.letter_code    (letter_code),
		.start_position (start_position),
		.line_number    (line_number),
		.paren_depth    (paren_depth),
		.letter_set     (letter_set),
		.last_token     (last_token)
	);

	token_checker #(
		.COUNT_WIDTH(COUNT_W)
	) checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.char_code          (char_code),
		.last_char          (last_char),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.kind               (kind),
		.letter_code        (letter_code),
		.start_position     (start_position),
		.line_number        (line_number),
		.paren_depth        (paren_depth),
		.letter_set         (letter_set),
		.last_token         (last_token),
		.mismatches         (mismatches),
		.tokens_outstanding (tokens_outstanding),
		.tokens_checked     (tokens_checked)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Watchdog: count cycles in which no word moves on either side. A correct
	// block never sits that long, even under the long sink hold-off.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == HANG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Token sink. Stall at random per the current phase; when a hold-off is
	// requested, keep stall high for that many cycles, counted here, so the
	// block backs up and has to stall its character input.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one character word and hold it until the block takes it. Any idle
	// gap is decided before offering, never from in_stall.
	task automatic send_char(input logic [7:0] c, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		chars_sent++;
		if (is_last)
			contents_closed++;
	endtask

	// Send a string; the final character closes the content when asked.
	task automatic send_text(input string s, input logic close_it);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close_it && (i == s.len() - 1));
	endtask

	// Drop valid and wait until every predicted token word has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_outstanding != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic roll_close();
		return ($urandom_range(19) == 0);
	endfunction

	function automatic logic [7:0] pick_letter();
		if ($urandom_range(1))
			return 8'(CH_UPPER_A + $urandom_range(25));
		return 8'(CH_LOWER_A + $urandom_range(25));
	endfunction

	// any of the skipped bytes: tab through carriage return, or space
	function automatic logic [7:0] pick_blank();
		if ($urandom_range(5) == 0)
			return CH_SPACE;
		return 8'($urandom_range(CH_CR, CH_TAB));
	endfunction

	// Sometimes stray whitespace between arrow characters, mostly none.
	task automatic maybe_blanks();
		int n;
		n = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
		repeat (n) send_char(pick_blank(), 1'b0);
	endtask

	// One piece of formula text. Well-formed pieces dominate; broken arrows
	// and raw bytes make up the rest. Any character but the start of a broken arrow
	// may close the content, arrows included, so contents also end inside an open match.
	task automatic send_fragment();
		int pick;
		pick = $urandom_range(99);
		if (pick < 22) begin
			send_char(pick_letter(), roll_close());
		end else if (pick < 30) begin
			send_char(CH_LPAREN, roll_close());
		end else if (pick < 38) begin
			send_char(CH_RPAREN, roll_close());
		end else if (pick < 50) begin
			case ($urandom_range(2))
				0: send_char(CH_AND, roll_close());
				1: send_char(CH_OR, roll_close());
				default: send_char(CH_NOT, roll_close());
			endcase
		end else if (pick < 62) begin
			send_char(CH_DASH, roll_close());
			maybe_blanks();
			send_char(CH_GT, roll_close());
		end else if (pick < 72) begin
			send_char(CH_LT, roll_close());
			maybe_blanks();
			send_char(CH_DASH, roll_close());
			maybe_blanks();
			send_char(CH_GT, roll_close());
		end else if (pick < 80) begin
			send_char(pick_blank(), roll_close());
		end else if (pick < 88) begin
			// start an arrow, then follow it with any byte, which usually breaks it
			case ($urandom_range(2))
				0: send_char(CH_LT, 1'b0);
				1: send_char(CH_DASH, 1'b0);
				default: begin
					send_char(CH_LT, 1'b0);
					send_char(CH_DASH, 1'b0);
				end
			endcase
			send_char(8'($urandom_range(255)), roll_close());
		end else begin
			send_char(8'($urandom_range(255)), roll_close());
		end
	endtask

	task automatic random_phase(input int idle_pct, input int stall_p);
		int target;
		send_idle_pct = idle_pct;
		stall_pct     = stall_p;
		target        = chars_sent + PHASE_WORDS;
		while (chars_sent < target)
			send_fragment();
		drain();
	endtask

	initial begin
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		char_code       <= 8'd0;
		last_char       <= 1'b0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		hold_cycles     = 0;
		chars_sent      = 0;
		contents_closed = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every token kind, arrows with blanks and a newline inside,
		// broken arrows of each shape, bytes outside the letter range, and a
		// content that ends inside an open arrow.
		send_text("(A z)v&~B\n", 1'b0);
		send_text("< \n- >-\t>", 1'b0);
		send_text("-x<-)<<", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'h80, 1'b0);
		send_text("Z-", 1'b1);
		drain();

		// Random text under each idle/stall mix.
		random_phase(0, 0);
		random_phase(54, 0);
		random_phase(0, 54);
		random_phase(8, 8);

		// Back-pressure: hold the sink off while words keep coming in.
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 80;
		repeat (40) send_fragment();
		drain();

		// one last random stretch so the run ends on mixed traffic
		random_phase(54, 54);

		$display("Sent %0d characters in %0d closed contents over idle, stall",
			chars_sent, contents_closed);
		$display("and long sink hold-off phases; %0d tokens compared.",
			tokens_checked);
		if (mismatches == 0 && tokens_outstanding == 0) begin
			$display("Verification passed");
		end else begin
			if (tokens_outstanding != 0)
				$error("%0d expected tokens never arrived", tokens_outstanding);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
